FILE: hdl/fcc_pkg.sv
// Shared types, codes and constants of the footprint collision checker.
package fcc_pkg;

  // Default sizes of the stores.
  localparam int DEF_HEADINGS      = 72;
  localparam int DEF_MAX_FOOTPRINT = 64;
  localparam int DEF_MAX_GRID_W    = 256;
  localparam int DEF_MAX_GRID_H    = 256;

  // Depth of the queue between front and back; a power of two.
  localparam int QDEPTH = 2;

  // Cell values that block a footprint.
  localparam logic [7:0] CELL_OCCUPIED = 8'd100;
  localparam logic [7:0] CELL_UNKNOWN  = 8'hFF;

  // Configuration register indexes.
  localparam logic [0:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_GRID_HEIGHT = 1'b1;
  localparam logic [8:0] CFG_DIM_RESET   = 9'd256;

  typedef enum logic [1:0] {
    KIND_CELL   = 2'd0,
    KIND_OFFSET = 2'd1,
    KIND_LENGTH = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_WALK,
    ST_EMIT
  } state_t;

  // Address field of a queue entry: wide enough for a grid cell, a template
  // offset or a heading index.
  function automatic int ent_addr_width(int hdg, int fp, int gw, int gh);
    int ga;
    int oa;
    int ha;
    ga = $clog2(gw * gh);
    oa = $clog2(hdg * fp);
    ha = $clog2(hdg);
    ent_addr_width = (ga > oa) ? ((ga > ha) ? ga : ha) : ((oa > ha) ? oa : ha);
  endfunction

  // kind + addr + 16-bit data + two 16-bit positions
  function automatic int ent_width(int hdg, int fp, int gw, int gh);
    ent_width = 2 + ent_addr_width(hdg, fp, gw, gh) + 48;
  endfunction

endpackage

FILE: hdl/fcc_front.sv
// Front end: accepts items, decodes the heading, checks ranges, builds queue entries.
module fcc_front #(
  parameter int HEADINGS      = fcc_pkg::DEF_HEADINGS,
  parameter int MAX_FOOTPRINT = fcc_pkg::DEF_MAX_FOOTPRINT,
  parameter int MAX_GRID_W    = fcc_pkg::DEF_MAX_GRID_W,
  parameter int MAX_GRID_H    = fcc_pkg::DEF_MAX_GRID_H,
  parameter int EW = fcc_pkg::ent_width(HEADINGS, MAX_FOOTPRINT, MAX_GRID_W, MAX_GRID_H)
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [7:0]  in_cell_value,
  input  logic [15:0]        in_heading_angle,
  input  logic [6:0]         in_template_heading,
  input  logic [5:0]         in_template_slot,
  input  logic signed [7:0]  in_offset_x,
  input  logic signed [7:0]  in_offset_y,
  input  logic [6:0]         in_template_length,
  output logic               q_valid,
  input  logic               q_ready,
  output logic [EW-1:0]      q_data
);
  import fcc_pkg::*;

  localparam int AW     = ent_addr_width(HEADINGS, MAX_FOOTPRINT, MAX_GRID_W, MAX_GRID_H);
  localparam int HP_W   = $clog2(HEADINGS + 1);
  localparam int PROD_W = 16 + HP_W;
  localparam int LEN_W  = $clog2(MAX_FOOTPRINT + 1);

  typedef struct packed {
    kind_t              kind;
    logic [AW-1:0]      addr;
    logic [15:0]        data;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } qent_t;

  qent_t             ent;
  logic              keep;
  logic [PROD_W-1:0] prod;
  logic [HP_W-1:0]   hdg;
  logic [LEN_W-1:0]  len_sat;

  always_comb begin
    // heading index = floor(angle * HEADINGS / 65536), clamped
    prod = PROD_W'(in_heading_angle) * PROD_W'(HEADINGS);
    hdg  = prod[PROD_W-1:16];
    if (int'(hdg) >= HEADINGS) begin
      hdg = HP_W'(HEADINGS - 1);
    end
    len_sat = (int'(in_template_length) > MAX_FOOTPRINT) ? LEN_W'(MAX_FOOTPRINT)
                                                         : LEN_W'(in_template_length);
    ent       = '0;
    ent.kind  = kind_t'(in_kind);
    ent.pos_x = in_pos_x;
    ent.pos_y = in_pos_y;
    keep      = 1'b0;
    unique case (kind_t'(in_kind))
      KIND_CELL: begin
        // drop writes that fall outside the store
        keep = (int'(in_pos_x) >= 0) && (int'(in_pos_x) < MAX_GRID_W) &&
               (int'(in_pos_y) >= 0) && (int'(in_pos_y) < MAX_GRID_H);
        ent.addr = AW'(int'(in_pos_y) * MAX_GRID_W + int'(in_pos_x));
        ent.data = {8'd0, in_cell_value};
      end
      KIND_OFFSET: begin
        keep = (int'(in_template_heading) < HEADINGS) &&
               (int'(in_template_slot) < MAX_FOOTPRINT);
        ent.addr = AW'(int'(in_template_heading) * MAX_FOOTPRINT + int'(in_template_slot));
        ent.data = {in_offset_y, in_offset_x};
      end
      KIND_LENGTH: begin
        keep     = int'(in_template_heading) < HEADINGS;
        ent.addr = AW'(in_template_heading);
        ent.data = 16'(len_sat);
      end
      KIND_QUERY: begin
        keep     = 1'b1;
        ent.addr = AW'(hdg);
      end
    endcase
  end

  assign in_ready = q_ready;
  assign q_valid  = in_valid && keep;
  assign q_data   = ent;

endmodule

FILE: hdl/fcc_queue.sv
// Short FIFO between the front and the back.
module fcc_queue #(
  parameter int EW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [EW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [EW-1:0] rd_data
);
  import fcc_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [EW-1:0]    slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = int'(cnt_r) < QDEPTH;
  assign rd_valid = cnt_r != '0;
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: hdl/fcc_back.sv
// Back end: stores, configuration registers and the footprint walk.
module fcc_back #(
  parameter int HEADINGS      = fcc_pkg::DEF_HEADINGS,
  parameter int MAX_FOOTPRINT = fcc_pkg::DEF_MAX_FOOTPRINT,
  parameter int MAX_GRID_W    = fcc_pkg::DEF_MAX_GRID_W,
  parameter int MAX_GRID_H    = fcc_pkg::DEF_MAX_GRID_H,
  parameter int EW = fcc_pkg::ent_width(HEADINGS, MAX_FOOTPRINT, MAX_GRID_W, MAX_GRID_H)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [EW-1:0] q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_clear,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [8:0]    cfg_wdata
);
  import fcc_pkg::*;

  localparam int AW    = ent_addr_width(HEADINGS, MAX_FOOTPRINT, MAX_GRID_W, MAX_GRID_H);
  localparam int HDG_W = (HEADINGS > 1) ? $clog2(HEADINGS) : 1;
  localparam int LEN_W = $clog2(MAX_FOOTPRINT + 1);
  localparam int OA_W  = $clog2(HEADINGS * MAX_FOOTPRINT);
  localparam int GA_W  = $clog2(MAX_GRID_W * MAX_GRID_H);
  localparam int GX_W  = $clog2(MAX_GRID_W);
  localparam int GY_W  = $clog2(MAX_GRID_H);
  localparam int WD_W  = $clog2(MAX_GRID_W + 1);
  localparam int HD_W  = $clog2(MAX_GRID_H + 1);

  typedef struct packed {
    kind_t              kind;
    logic [AW-1:0]      addr;
    logic [15:0]        data;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } qent_t;

  qent_t ent;
  assign ent = q_data;

  // stores
  logic [7:0]       occ_mem [MAX_GRID_W * MAX_GRID_H];
  logic [15:0]      ofs_mem [HEADINGS * MAX_FOOTPRINT];
  logic [LEN_W-1:0] len_mem [HEADINGS];
  logic [HEADINGS-1:0] len_vld_r;

  logic             occ_we, ofs_we, len_we;
  logic [GA_W-1:0]  occ_raddr;
  logic [OA_W-1:0]  ofs_raddr;
  logic [7:0]       occ_rd_r;
  logic [15:0]      ofs_rd_r;
  logic [LEN_W-1:0] len_rd_r;
  logic             len_hit_r;

  // configuration
  logic [8:0]      grid_w_r, grid_h_r;
  logic [WD_W-1:0] w_lim;
  logic [HD_W-1:0] h_lim;

  // control
  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   n_r, n_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic [OA_W-1:0]    base_r;
  logic signed [15:0] px_r, py_r;
  logic               res_r, res_nxt;
  logic               s1_vld_r, s1_vld_nxt, s1_last_r, s1_last_nxt;
  logic               s2_vld_r, s2_vld_nxt, s2_last_r, s2_last_nxt;
  logic               s2_off_r, s2_off_nxt;
  logic               out_valid_r, out_valid_nxt, out_clear_r, out_clear_nxt;
  logic               pop_query;

  logic signed [16:0] cx, cy;
  logic               off;
  logic               blocked;

  assign w_lim = (int'(grid_w_r) > MAX_GRID_W) ? WD_W'(MAX_GRID_W) : WD_W'(grid_w_r);
  assign h_lim = (int'(grid_h_r) > MAX_GRID_H) ? HD_W'(MAX_GRID_H) : HD_W'(grid_h_r);

  // stage 1: covered cell from the template offset
  assign cx  = 17'(px_r) + 17'(signed'(ofs_rd_r[7:0]));
  assign cy  = 17'(py_r) + 17'(signed'(ofs_rd_r[15:8]));
  assign off = cx[16] || cy[16] || (int'(cx) >= int'(w_lim)) || (int'(cy) >= int'(h_lim));
  assign occ_raddr = GA_W'(int'(cy[GY_W-1:0]) * MAX_GRID_W + int'(cx[GX_W-1:0]));

  // stage 2: cell value check
  assign blocked = s2_off_r || (occ_rd_r == CELL_OCCUPIED) || (occ_rd_r == CELL_UNKNOWN);

  assign q_ready   = (state_r == ST_IDLE);
  assign pop_query = q_valid && q_ready && (ent.kind == KIND_QUERY);

  always_comb begin
    occ_we = 1'b0;
    ofs_we = 1'b0;
    len_we = 1'b0;
    if (q_valid && q_ready) begin
      unique case (ent.kind)
        KIND_CELL:   occ_we = 1'b1;
        KIND_OFFSET: ofs_we = 1'b1;
        KIND_LENGTH: len_we = 1'b1;
        KIND_QUERY:  ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    s1_vld_nxt    = 1'b0;
    s1_last_nxt   = 1'b0;
    s2_vld_nxt    = 1'b0;
    s2_last_nxt   = s1_last_r;
    s2_off_nxt    = off;
    ofs_raddr     = base_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_clear_nxt = out_clear_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_query) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        n_nxt   = len_hit_r ? len_rd_r : '0;
        idx_nxt = '0;
        if (!len_hit_r || len_rd_r == '0) begin
          res_nxt   = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // issue one offset read a cycle
        if (idx_r < n_r) begin
          ofs_raddr   = OA_W'(int'(base_r) + int'(idx_r));
          s1_vld_nxt  = 1'b1;
          s1_last_nxt = (LEN_W'(idx_r + 1'b1) == n_r);
          idx_nxt     = idx_r + 1'b1;
        end
        s2_vld_nxt = s1_vld_r;
        if (s2_vld_r && (blocked || s2_last_r)) begin
          // drop whatever is still in flight
          res_nxt    = !blocked;
          state_nxt  = ST_EMIT;
          s1_vld_nxt = 1'b0;
          s2_vld_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_clear_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      len_vld_r   <= '0;
      grid_w_r    <= CFG_DIM_RESET;
      grid_h_r    <= CFG_DIM_RESET;
    end else begin
      state_r     <= state_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (len_we) begin
        len_vld_r[ent.addr[HDG_W-1:0]] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_w_r <= cfg_wdata;
          CFG_GRID_HEIGHT: grid_h_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    idx_r       <= idx_nxt;
    res_r       <= res_nxt;
    s1_last_r   <= s1_last_nxt;
    s2_last_r   <= s2_last_nxt;
    s2_off_r    <= s2_off_nxt;
    out_clear_r <= out_clear_nxt;
    if (pop_query) begin
      px_r   <= ent.pos_x;
      py_r   <= ent.pos_y;
      base_r <= OA_W'(int'(ent.addr[HDG_W-1:0]) * MAX_FOOTPRINT);
    end
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[ent.addr[GA_W-1:0]] <= ent.data[7:0];
    end
    occ_rd_r <= occ_mem[occ_raddr];
  end

  always_ff @(posedge clk) begin
    if (ofs_we) begin
      ofs_mem[ent.addr[OA_W-1:0]] <= ent.data;
    end
    ofs_rd_r <= ofs_mem[ofs_raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[ent.addr[HDG_W-1:0]] <= ent.data[LEN_W-1:0];
    end
    len_rd_r  <= len_mem[ent.addr[HDG_W-1:0]];
    len_hit_r <= len_vld_r[ent.addr[HDG_W-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_clear = out_clear_r;

endmodule

FILE: hdl/footprint_collision_check.sv
// Top level of the footprint collision checker: front, queue and back joined.
//
// Checks a vehicle footprint against an occupancy grid of signed bytes. Write
// items load grid cells, per-heading template offsets and template lengths; a
// query item gives a cell position and a heading (a 16-bit fraction of a full
// turn) and returns one item, clear = 1 when every covered cell lies on the
// configured grid and holds neither 100 (occupied) nor -1 (unknown). Write
// items give no result. The front decodes each item and hands it through a
// two-entry queue to the back, so input items are still taken, until the queue
// is full, while the back walks a template or a result waits at the output
// register. A write is stored as it leaves the queue; a query walks every
// offset of a template that turns out clear, stops early at a blocked cell
// and ends at once for an empty template. The walk reads one template offset
// and one grid cell a cycle, so the template length sets the rate.
// Grid cells and template offsets read before they were ever written give
// undefined answers; template lengths reset to zero. grid_width and
// grid_height reset to 256 and are taken as at most MAX_GRID_W / MAX_GRID_H;
// write them only while the block is idle.
module footprint_collision_check #(
  parameter int HEADINGS      = fcc_pkg::DEF_HEADINGS,
  parameter int MAX_FOOTPRINT = fcc_pkg::DEF_MAX_FOOTPRINT,
  parameter int MAX_GRID_W    = fcc_pkg::DEF_MAX_GRID_W,
  parameter int MAX_GRID_H    = fcc_pkg::DEF_MAX_GRID_H
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [7:0]  in_cell_value,
  input  logic [15:0]        in_heading_angle,
  input  logic [6:0]         in_template_heading,
  input  logic [5:0]         in_template_slot,
  input  logic signed [7:0]  in_offset_x,
  input  logic signed [7:0]  in_offset_y,
  input  logic [6:0]         in_template_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_clear,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [8:0]         cfg_wdata
);
  import fcc_pkg::*;

  // Width of one queue entry: kind, address, data and the query position.
  localparam int EW = ent_width(HEADINGS, MAX_FOOTPRINT, MAX_GRID_W, MAX_GRID_H);

  logic          fq_valid, fq_ready;
  logic [EW-1:0] fq_data;
  logic          qb_valid, qb_ready;
  logic [EW-1:0] qb_data;

  // Decode the item, drop writes that miss the stores, map heading to index.
  fcc_front #(
    .HEADINGS      (HEADINGS),
    .MAX_FOOTPRINT (MAX_FOOTPRINT),
    .MAX_GRID_W    (MAX_GRID_W),
    .MAX_GRID_H    (MAX_GRID_H),
    .EW            (EW)
  ) u_front (
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_cell_value       (in_cell_value),
    .in_heading_angle    (in_heading_angle),
    .in_template_heading (in_template_heading),
    .in_template_slot    (in_template_slot),
    .in_offset_x         (in_offset_x),
    .in_offset_y         (in_offset_y),
    .in_template_length  (in_template_length),
    .q_valid             (fq_valid),
    .q_ready             (fq_ready),
    .q_data              (fq_data)
  );

  // Hold decoded items while the back is busy walking a template.
  fcc_queue #(
    .EW (EW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // Perform writes in order and walk templates for queries.
  fcc_back #(
    .HEADINGS      (HEADINGS),
    .MAX_FOOTPRINT (MAX_FOOTPRINT),
    .MAX_GRID_W    (MAX_GRID_W),
    .MAX_GRID_H    (MAX_GRID_H),
    .EW            (EW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_clear (out_clear),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

FILE: tb/sv/fcc_tb_pkg.sv
// Item type, heading lookup and scoreboard for the footprint collision checker bench.
package fcc_tb_pkg;
  import fcc_pkg::*;

  localparam int HDGS = DEF_HEADINGS;
  localparam int FP   = DEF_MAX_FOOTPRINT;
  localparam int GW   = DEF_MAX_GRID_W;
  localparam int GH   = DEF_MAX_GRID_H;

  typedef struct {
    kind_t              kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [7:0]  cell_value;
    logic [15:0]        heading_angle;
    logic [6:0]         template_heading;
    logic [5:0]         template_slot;
    logic signed [7:0]  offset_x;
    logic signed [7:0]  offset_y;
    logic [6:0]         template_length;
  } fcc_item_t;

  // First store entry that a walk would read before it was ever written.
  typedef enum int {
    GAP_NONE,
    GAP_OFFSET,
    GAP_CELL
  } walk_gap_t;

  typedef struct {
    bit clear;
    int serial;
  } clear_due_t;

  function automatic int heading_of(logic [15:0] angle);
    int h;
    h = (int'(angle) * HDGS) >> 16;
    if (h >= HDGS) h = HDGS - 1;
    return h;
  endfunction

  class clear_scoreboard;
    logic [7:0]  occupancy [GW*GH];
    bit          cell_known [GW*GH];
    logic [15:0] offsets [HDGS*FP];
    bit          offset_known [HDGS*FP];
    int          lengths [HDGS];
    int          grid_w;
    int          grid_h;
    clear_due_t  clear_due [$];
    int          queries;

    function new();
      grid_w  = int'(CFG_DIM_RESET);
      grid_h  = int'(CFG_DIM_RESET);
      queries = 0;
    endfunction

    function void set_dim(logic [0:0] idx, logic [8:0] value);
      if (idx == CFG_GRID_WIDTH) grid_w = int'(value);
      else grid_h = int'(value);
    endfunction

    // Walk the template of one heading; report the first unwritten entry met.
    function bit footprint_clear(input int px, input int py, input int hdg,
                                 output walk_gap_t gap, output int addr);
      int n;
      int w;
      int h;
      int cx;
      int cy;
      int base;
      logic [15:0] e;
      logic [7:0] c;
      gap  = GAP_NONE;
      addr = 0;
      w    = grid_w > GW ? GW : grid_w;
      h    = grid_h > GH ? GH : grid_h;
      n    = lengths[hdg];
      base = hdg * FP;
      for (int i = 0; i < n; i++) begin
        if (!offset_known[base+i]) begin
          gap  = GAP_OFFSET;
          addr = i;
          return 1'b0;
        end
        e  = offsets[base+i];
        cx = px + int'($signed(e[7:0]));
        cy = py + int'($signed(e[15:8]));
        if (cx >= 0 && cx < GW && cy >= 0 && cy < GH && !cell_known[cy*GW+cx]) begin
          gap  = GAP_CELL;
          addr = cy * GW + cx;
          return 1'b0;
        end
        if (cx < 0 || cy < 0 || cx >= w || cy >= h) return 1'b0;
        c = occupancy[cy*GW+cx];
        if (c == CELL_OCCUPIED || c == CELL_UNKNOWN) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Apply one accepted item; returns 0 for an item the block ignores.
    function bit absorb_item(fcc_item_t it);
      int px;
      int py;
      int th;
      int addr;
      walk_gap_t gap;
      clear_due_t due;
      px = int'(it.pos_x);
      py = int'(it.pos_y);
      th = int'(it.template_heading);
      case (it.kind)
        KIND_CELL: begin
          if (px < 0 || px >= GW || py < 0 || py >= GH) return 1'b0;
          occupancy[py*GW+px]  = it.cell_value;
          cell_known[py*GW+px] = 1'b1;
        end
        KIND_OFFSET: begin
          if (th >= HDGS) return 1'b0;
          offsets[th*FP+int'(it.template_slot)]      = {it.offset_y, it.offset_x};
          offset_known[th*FP+int'(it.template_slot)] = 1'b1;
        end
        KIND_LENGTH: begin
          if (th >= HDGS) return 1'b0;
          lengths[th] = it.template_length > FP ? FP : int'(it.template_length);
        end
        default: begin
          due.clear  = footprint_clear(px, py, heading_of(it.heading_angle), gap, addr);
          due.serial = queries++;
          clear_due.push_back(due);
        end
      endcase
      return 1'b1;
    endfunction

    function int outstanding();
      return clear_due.size();
    endfunction

    function bit match_clear(input logic got, output string msg);
      clear_due_t due;
      msg = "";
      if (clear_due.size() == 0) begin
        msg = $sformatf("clear=%b arrived with no query outstanding", got);
        return 1'b0;
      end
      due = clear_due.pop_front();
      if (got !== due.clear) begin
        msg = $sformatf("query %0d: clear=%b, expected %b", due.serial, got, due.clear);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
// Self-checking bench for the footprint collision checker: directed items, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcc_pkg::*;
  import fcc_tb_pkg::*;

  // Cycles to let the back finish any write item after the last result; a
  // query walks at most MAX_FOOTPRINT offsets, so this is ample.
  localparam int SETTLE_CYCLES = 100;
  // Long hold-off on the result side, long enough to fill the queue.
  localparam int RESULT_HOLD   = 400;
  localparam int PHASE_ITEMS   = 70;
  localparam int NUM_PHASES    = 9;
  // Worst case stays far below this limit even with every query walking a full
  // template behind long stalls on both sides.
  localparam int LIMIT_NS      = 16_000_000;

  logic               clk                 = 1'b0;
  logic               rst_n               = 1'b0;
  logic               in_valid            = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind             = '0;
  logic signed [15:0] in_pos_x            = '0;
  logic signed [15:0] in_pos_y            = '0;
  logic signed [7:0]  in_cell_value       = '0;
  logic [15:0]        in_heading_angle    = '0;
  logic [6:0]         in_template_heading = '0;
  logic [5:0]         in_template_slot    = '0;
  logic signed [7:0]  in_offset_x         = '0;
  logic signed [7:0]  in_offset_y         = '0;
  logic [6:0]         in_template_length  = '0;
  logic               out_valid;
  logic               out_ready           = 1'b0;
  logic               out_clear;
  logic               cfg_we              = 1'b0;
  logic [0:0]         cfg_index           = '0;
  logic [8:0]         cfg_wdata           = '0;

  footprint_collision_check dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_cell_value       (in_cell_value),
    .in_heading_angle    (in_heading_angle),
    .in_template_heading (in_template_heading),
    .in_template_slot    (in_template_slot),
    .in_offset_x         (in_offset_x),
    .in_offset_y         (in_offset_y),
    .in_template_length  (in_template_length),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_clear           (out_clear),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  clear_scoreboard sb;
  int errors        = 0;
  int counted       = 0;   // accepted items that the block acts on
  bit hold_results  = 1'b0;
  bit sender_eager  = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: end the run if anything hangs.
  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(input string msg);
    errors++;
    $display("%0t ns  MISMATCH  %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------
  // Result side: check every accepted result against the oldest query.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      if (!sb.match_clear(out_clear, msg)) report(msg);
    end
  end

  // Drive out_ready in bursts: mostly open, short stalls, the odd long one.
  // A requested hold-off is counted out here, independent of the sender.
  initial begin
    int  r;
    int  span;
    bit  level;
    forever begin
      if (hold_results) begin
        out_ready = 1'b0;
        repeat (RESULT_HOLD) @(negedge clk);
        hold_results = 1'b0;
      end
      r = $urandom_range(99);
      if (r < 50) begin
        level = 1'b1;
        span  = $urandom_range(20, 1);
      end else if (r < 90) begin
        level = 1'b0;
        span  = $urandom_range(3, 1);
      end else begin
        level = 1'b0;
        span  = $urandom_range(40, 10);
      end
      out_ready = level;
      repeat (span) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Fill every field with noise so unused fields toggle too.
  function automatic fcc_item_t noise_item(kind_t k);
    fcc_item_t it;
    it.kind             = k;
    it.pos_x            = 16'($urandom);
    it.pos_y            = 16'($urandom);
    it.cell_value       = 8'($urandom);
    it.heading_angle    = 16'($urandom);
    it.template_heading = 7'($urandom);
    it.template_slot    = 6'($urandom);
    it.offset_x         = 8'($urandom);
    it.offset_y         = 8'($urandom);
    it.template_length  = 7'($urandom);
    return it;
  endfunction

  // Mostly free cells, with a sprinkling of occupied and unknown ones.
  function automatic logic [7:0] pick_cell();
    int r;
    logic [7:0] v;
    r = $urandom_range(99);
    if (r < 5) return CELL_OCCUPIED;
    if (r < 10) return CELL_UNKNOWN;
    v = 8'($urandom);
    if (v == CELL_OCCUPIED || v == CELL_UNKNOWN) v = 8'h00;
    return v;
  endfunction

  // Compact footprints mostly, so walks revisit a small patch of the grid.
  function automatic logic [7:0] pick_offset();
    if ($urandom_range(99) < 90) return 8'(int'($urandom_range(6)) - 3);
    return 8'($urandom);
  endfunction

  // Near the origin, near the far edge, or anywhere in the 16-bit range.
  function automatic int pick_coord(int dim);
    int eff;
    int r;
    eff = dim > 256 ? 256 : dim;
    r   = $urandom_range(99);
    if (r < 75) return int'($urandom_range(22)) - 2;
    if (r < 90) return eff - 3 + int'($urandom_range(5));
    return int'($signed(16'($urandom)));
  endfunction

  // Random angle that maps onto heading index h.
  function automatic logic [15:0] angle_for(int h);
    int lo;
    int hi;
    lo = (h * 65536 + HDGS - 1) / HDGS;
    hi = ((h + 1) * 65536 + HDGS - 1) / HDGS - 1;
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // Offer one item; hold it until accepted, then book it with the scoreboard.
  task automatic send_item(input fcc_item_t it);
    int gap;
    gap = sender_eager ? 0 : idle_length();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind             = it.kind;
    in_pos_x            = it.pos_x;
    in_pos_y            = it.pos_y;
    in_cell_value       = it.cell_value;
    in_heading_angle    = it.heading_angle;
    in_template_heading = it.template_heading;
    in_template_slot    = it.template_slot;
    in_offset_x         = it.offset_x;
    in_offset_y         = it.offset_y;
    in_template_length  = it.template_length;
    in_valid            = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (sb.absorb_item(it)) counted++;
  endtask

  task automatic send_cell(input int x, input int y, input logic [7:0] value);
    fcc_item_t it;
    it            = noise_item(KIND_CELL);
    it.pos_x      = 16'(x);
    it.pos_y      = 16'(y);
    it.cell_value = value;
    send_item(it);
  endtask

  task automatic send_offset(input int h, input int slot,
                             input logic [7:0] ox, input logic [7:0] oy);
    fcc_item_t it;
    it                  = noise_item(KIND_OFFSET);
    it.template_heading = 7'(h);
    it.template_slot    = 6'(slot);
    it.offset_x         = ox;
    it.offset_y         = oy;
    send_item(it);
  endtask

  task automatic send_length(input int h, input int len);
    fcc_item_t it;
    it                  = noise_item(KIND_LENGTH);
    it.template_heading = 7'(h);
    it.template_length  = 7'(len);
    send_item(it);
  endtask

  // Load a template: length first, then every slot it uses.
  task automatic set_template(input int h, input int len);
    int n;
    send_length(h, len);
    n = len > FP ? FP : len;
    for (int s = 0; s < n; s++) send_offset(h, s, pick_offset(), pick_offset());
  endtask

  // Issue a query, first writing any offset or cell its walk would read
  // unwritten; repeat until the walk touches only known entries.
  task automatic send_query(input int px, input int py, input logic [15:0] angle);
    fcc_item_t it;
    walk_gap_t gap;
    int addr;
    int hdg;
    bit unused;
    hdg    = heading_of(angle);
    unused = sb.footprint_clear(px, py, hdg, gap, addr);
    while (gap != GAP_NONE) begin
      if (gap == GAP_OFFSET) send_offset(hdg, addr, pick_offset(), pick_offset());
      else send_cell(addr % GW, addr / GW, pick_cell());
      unused = sb.footprint_clear(px, py, hdg, gap, addr);
    end
    it               = noise_item(KIND_QUERY);
    it.pos_x         = 16'(px);
    it.pos_y         = 16'(py);
    it.heading_angle = angle;
    send_item(it);
  endtask

  // Drop valid and wait until every result is in and the back has gone quiet.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input int value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = 9'(value);
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_dim(idx, 9'(value));
  endtask

  // Edge cases on the reset 256 x 256 grid.
  task automatic directed_items();
    // Writes the block must drop: cells off the store, headings past the end.
    send_cell(-1, 0, CELL_OCCUPIED);
    send_cell(256, 3, CELL_UNKNOWN);
    send_cell(32767, -32768, CELL_UNKNOWN);
    send_offset(HDGS, 0, 8'h00, 8'h00);
    send_offset(127, 63, 8'h7F, 8'h80);
    send_length(HDGS, 5);
    send_length(127, 127);
    // Empty templates pass anywhere, even at the far corners of the range.
    send_query(0, 0, 16'h0000);
    send_query(32767, -32768, 16'hFFFF);
    // Single-cell footprints at the extreme offsets.
    send_cell(0, 0, CELL_OCCUPIED);
    send_cell(255, 255, CELL_UNKNOWN);
    send_cell(1, 1, 8'h80);
    send_cell(254, 254, 8'h7F);
    send_length(3, 1);
    send_offset(3, 0, 8'h80, 8'h80);
    send_length(4, 1);
    send_offset(4, 0, 8'h7F, 8'h7F);
    send_query(128, 128, angle_for(3));
    send_query(129, 129, angle_for(3));
    send_query(128, 128, angle_for(4));
    send_query(127, 127, angle_for(4));
    send_query(129, 128, angle_for(4));
    send_query(127, 128, angle_for(3));
    // Over-long length saturates to a full template; last slot written first.
    send_length(1, 127);
    send_offset(1, FP - 1, 8'h00, 8'h00);
    send_query(10, 10, angle_for(1));
  endtask

  // One random phase: load a handful of templates, then mostly queries
  // against them, with rewrites and ignored noise mixed in.
  task automatic run_phase(input int phase, input int quota);
    int active [5];
    int start;
    int r;
    int k;
    int len;
    bit pressed;
    pressed = 1'b0;
    foreach (active[i]) active[i] = $urandom_range(HDGS - 1);
    active[0] = (phase % 2 == 0) ? 0 : HDGS - 1;
    foreach (active[i]) begin
      r = $urandom_range(99);
      if (r < 5) len = 0;
      else if (r < 7) len = $urandom_range(127, FP + 1);
      else if (r < 15) len = $urandom_range(FP, 20);
      else len = $urandom_range(8, 1);
      set_template(active[i], len);
    end
    start = counted;
    while (counted - start < quota) begin
      if (!pressed && counted - start >= quota / 2) begin
        pressed = 1'b1;
        // Starve the result side while items keep coming, to back up the queue.
        if (phase == 1) hold_results = 1'b1;
        // Pause the sender until the block has emptied.
        if (phase == 4) wait_drained();
      end
      r = $urandom_range(99);
      k = $urandom_range(4);
      if (r < 55) begin
        send_query(pick_coord(sb.grid_w), pick_coord(sb.grid_h), angle_for(active[k]));
      end else if (r < 62) begin
        send_query(pick_coord(sb.grid_w), pick_coord(sb.grid_h), 16'($urandom));
      end else if (r < 72) begin
        send_cell(pick_coord(sb.grid_w), pick_coord(sb.grid_h), pick_cell());
      end else if (r < 82) begin
        send_offset(active[k], $urandom_range(FP - 1), pick_offset(), pick_offset());
      end else if (r < 87) begin
        set_template(active[k], $urandom_range(8));
      end else if (r < 95) begin
        case ($urandom_range(2))
          0: send_offset($urandom_range(127, HDGS), $urandom_range(FP - 1),
                         8'($urandom), 8'($urandom));
          1: send_length($urandom_range(127, HDGS), $urandom_range(127));
          default: send_cell(int'($signed(16'($urandom))),
                             int'($signed(16'($urandom))), 8'($urandom));
        endcase
      end else begin
        send_query(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                   angle_for(active[k]));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int phase_w [NUM_PHASES];
    int phase_h [NUM_PHASES];
    sb = new();
    // Reset values first, then small, zero, minimum, oversized and lopsided grids.
    phase_w = '{256, 24, 0, 1, 511, 30, 256, 200, 0};
    phase_h = '{256, 20, 30, 1, 400, 0, 1, 256, 0};
    phase_w[NUM_PHASES-1] = $urandom_range(256, 1);
    phase_h[NUM_PHASES-1] = $urandom_range(256, 1);

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    directed_items();
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_cfg(CFG_GRID_WIDTH, phase_w[p]);
        write_cfg(CFG_GRID_HEIGHT, phase_h[p]);
      end
      sender_eager = (p == 3 || p == 6);
      run_phase(p, PHASE_ITEMS);
    end
    wait_drained();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
